[hw/rtl/efrs_pkg.sv]
// shared widths and reset constants for the earliest free resource scheduler
package efrs_pkg;

  localparam int unsigned IN_TIME_W  = 32;
  localparam int unsigned OUT_ROOM_W = 4;
  localparam int unsigned OUT_TIME_W = 48;
  localparam int unsigned CFG_W      = 5;

  localparam logic [CFG_W-1:0] ROOM_COUNT_RST = 5'd16;

endpackage

[hw/rtl/efrs_cell.sv]
// one resource cell: holds finish time and use count, refines the passing scan packet
module efrs_cell #(
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CW         = 5,
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [CW-1:0]         n_i,
  input  logic [TIME_BITS-1:0]  start_i,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic [TIME_BITS-1:0]  wr_finish_i,
  input  logic [COUNT_BITS-1:0] wr_uses_i,
  input  logic                  pv_i,
  input  logic                  found_i,
  input  logic [IDX_W-1:0]      free_idx_i,
  input  logic [COUNT_BITS-1:0] free_uses_i,
  input  logic [IDX_W-1:0]      early_idx_i,
  input  logic [TIME_BITS-1:0]  early_fin_i,
  input  logic [COUNT_BITS-1:0] early_uses_i,
  output logic                  pv_o,
  output logic                  found_o,
  output logic [IDX_W-1:0]      free_idx_o,
  output logic [COUNT_BITS-1:0] free_uses_o,
  output logic [IDX_W-1:0]      early_idx_o,
  output logic [TIME_BITS-1:0]  early_fin_o,
  output logic [COUNT_BITS-1:0] early_uses_o
);

  logic [TIME_BITS-1:0]  finish_q;
  logic [COUNT_BITS-1:0] uses_q;
  logic                  pv_q;
  logic                  found_q;
  logic [IDX_W-1:0]      free_idx_q;
  logic [COUNT_BITS-1:0] free_uses_q;
  logic [IDX_W-1:0]      early_idx_q;
  logic [TIME_BITS-1:0]  early_fin_q;
  logic [COUNT_BITS-1:0] early_uses_q;

  logic active;
  logic take_free;
  logic take_early;

  assign active     = CW'(idx_i) < n_i;
  assign take_free  = active && !found_i && (finish_q <= start_i);
  assign take_early = active && ((idx_i == '0) || (finish_q < early_fin_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finish_q <= '0;
      uses_q   <= '0;
    end else if (wr_en_i && (wr_idx_i == idx_i)) begin
      finish_q <= wr_finish_i;
      uses_q   <= wr_uses_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= pv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q      <= found_i || take_free;
    free_idx_q   <= take_free ? idx_i : free_idx_i;
    free_uses_q  <= take_free ? uses_q : free_uses_i;
    early_idx_q  <= take_early ? idx_i : early_idx_i;
    early_fin_q  <= take_early ? finish_q : early_fin_i;
    early_uses_q <= take_early ? uses_q : early_uses_i;
  end

  assign pv_o         = pv_q;
  assign found_o      = found_q;
  assign free_idx_o   = free_idx_q;
  assign free_uses_o  = free_uses_q;
  assign early_idx_o  = early_idx_q;
  assign early_fin_o  = early_fin_q;
  assign early_uses_o = early_uses_q;

endmodule

[hw/rtl/earliest_free_resource_scheduler.sv]
// top level: request control, chain of resource cells, commit and result register
//
// usage
//   config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the resource count;
//   it is always ready, zero counts as one and values above MAX_ROOMS as MAX_ROOMS.
//   request channel (in_valid_i/in_ready_o) takes start_time_i and end_time_i,
//   with start times in nondecreasing order.
//   result channel (out_valid_o/out_ready_i) returns one result per request.
// sequencing
//   a scan packet walks the cell chain one cell per cycle; a request passes the
//   launch register, each cell's register, the result register and the output
//   register, and the next request is accepted only after the previous one commits.
//   the scan always passes all MAX_ROOMS cells, whatever the resource count.
// reset
//   all finish times, use counts and the busiest tracker clear at once,
//   the resource count returns to 16, no result is pending.
// stall
//   a waiting result sits in the output register; the next request is scanned
//   meanwhile and its commit holds until the output register frees up.
module earliest_free_resource_scheduler #(
  parameter int unsigned MAX_ROOMS  = 16,
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [efrs_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [efrs_pkg::IN_TIME_W-1:0]   start_time_i,
  input  logic [efrs_pkg::IN_TIME_W-1:0]   end_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [efrs_pkg::OUT_ROOM_W-1:0]  granted_room_o,
  output logic [efrs_pkg::OUT_TIME_W-1:0]  actual_start_o,
  output logic [efrs_pkg::OUT_TIME_W-1:0]  actual_finish_o,
  output logic                             was_delayed_o,
  output logic [efrs_pkg::OUT_ROOM_W-1:0]  busiest_room_o
);

  import efrs_pkg::*;

  localparam int unsigned IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int unsigned NCW   = $clog2(MAX_ROOMS + 1);
  localparam int unsigned CW    = (NCW > CFG_W) ? NCW : CFG_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CFG_W-1:0]      room_count_q;
  logic [CW-1:0]         n_eff;
  logic                  launch_q;
  logic [TIME_BITS-1:0]  start_q;
  logic [IN_TIME_W-1:0]  dur_q;

  logic                  res_found_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic [COUNT_BITS-1:0] res_uses_q;
  logic [TIME_BITS-1:0]  res_fin_q;

  logic [COUNT_BITS-1:0] best_count_q;
  logic [IDX_W-1:0]      best_room_q;

  logic                  out_valid_q;
  logic [OUT_ROOM_W-1:0] out_room_q;
  logic [OUT_TIME_W-1:0] out_start_q;
  logic [OUT_TIME_W-1:0] out_finish_q;
  logic                  out_delayed_q;
  logic [OUT_ROOM_W-1:0] out_best_q;

  logic                  in_fire;
  logic                  commit;
  logic [TIME_BITS-1:0]  a_start;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS-1:0]  a_finish;
  logic [COUNT_BITS-1:0] new_uses;
  logic                  best_upd;
  logic                  best_room_upd;
  logic [IDX_W-1:0]      new_best_room;

  logic [IDX_W+OUT_ROOM_W-1:0]     room_ext;
  logic [IDX_W+OUT_ROOM_W-1:0]     best_ext;
  logic [TIME_BITS+OUT_TIME_W-1:0] start_ext;
  logic [TIME_BITS+OUT_TIME_W-1:0] finish_ext;

  logic                  pv        [MAX_ROOMS+1];
  logic                  found     [MAX_ROOMS+1];
  logic [IDX_W-1:0]      free_idx  [MAX_ROOMS+1];
  logic [COUNT_BITS-1:0] free_uses [MAX_ROOMS+1];
  logic [IDX_W-1:0]      early_idx [MAX_ROOMS+1];
  logic [TIME_BITS-1:0]  early_fin [MAX_ROOMS+1];
  logic [COUNT_BITS-1:0] early_uses[MAX_ROOMS+1];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign commit      = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (room_count_q == '0) begin
      n_eff = CW'(1);
    end else if (CW'(room_count_q) > CW'(MAX_ROOMS)) begin
      n_eff = CW'(MAX_ROOMS);
    end else begin
      n_eff = CW'(room_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= ROOM_COUNT_RST;
    end else if (cfg_valid_i) begin
      room_count_q <= cfg_data_i;
    end
  end

  // scan packet entry
  assign pv[0]         = launch_q;
  assign found[0]      = 1'b0;
  assign free_idx[0]   = '0;
  assign free_uses[0]  = '0;
  assign early_idx[0]  = '0;
  assign early_fin[0]  = '1;
  assign early_uses[0] = '0;

  for (genvar g = 0; g < MAX_ROOMS; g++) begin : g_cell
    efrs_cell #(
      .IDX_W      (IDX_W),
      .CW         (CW),
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (IDX_W'(g)),
      .n_i          (n_eff),
      .start_i      (start_q),
      .wr_en_i      (commit),
      .wr_idx_i     (res_idx_q),
      .wr_finish_i  (a_finish),
      .wr_uses_i    (new_uses),
      .pv_i         (pv[g]),
      .found_i      (found[g]),
      .free_idx_i   (free_idx[g]),
      .free_uses_i  (free_uses[g]),
      .early_idx_i  (early_idx[g]),
      .early_fin_i  (early_fin[g]),
      .early_uses_i (early_uses[g]),
      .pv_o         (pv[g+1]),
      .found_o      (found[g+1]),
      .free_idx_o   (free_idx[g+1]),
      .free_uses_o  (free_uses[g+1]),
      .early_idx_o  (early_idx[g+1]),
      .early_fin_o  (early_fin[g+1]),
      .early_uses_o (early_uses[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (pv[MAX_ROOMS]) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= TIME_BITS'(start_time_i);
      dur_q   <= (end_time_i > start_time_i) ? (end_time_i - start_time_i) : '0;
    end
    if ((state_q == S_SCAN) && pv[MAX_ROOMS]) begin
      res_found_q <= found[MAX_ROOMS];
      res_idx_q   <= found[MAX_ROOMS] ? free_idx[MAX_ROOMS] : early_idx[MAX_ROOMS];
      res_uses_q  <= found[MAX_ROOMS] ? free_uses[MAX_ROOMS] : early_uses[MAX_ROOMS];
      res_fin_q   <= early_fin[MAX_ROOMS];
    end
  end

  // commit arithmetic
  assign a_start  = res_found_q ? start_q : res_fin_q;
  assign sum      = {1'b0, a_start} + (TIME_BITS + 1)'(dur_q);
  assign a_finish = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign new_uses = (res_uses_q == '1) ? res_uses_q : res_uses_q + COUNT_BITS'(1);

  assign best_upd      = new_uses > best_count_q;
  assign best_room_upd = best_upd || ((new_uses == best_count_q) && (res_idx_q < best_room_q));
  assign new_best_room = best_room_upd ? res_idx_q : best_room_q;

  assign room_ext   = {{OUT_ROOM_W{1'b0}}, res_idx_q};
  assign best_ext   = {{OUT_ROOM_W{1'b0}}, new_best_room};
  assign start_ext  = {{OUT_TIME_W{1'b0}}, a_start};
  assign finish_ext = {{OUT_TIME_W{1'b0}}, a_finish};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_count_q <= '0;
      best_room_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (commit) begin
        if (best_upd) best_count_q <= new_uses;
        best_room_q <= new_best_room;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_room_q    <= room_ext[OUT_ROOM_W-1:0];
      out_start_q   <= start_ext[OUT_TIME_W-1:0];
      out_finish_q  <= finish_ext[OUT_TIME_W-1:0];
      out_delayed_q <= !res_found_q;
      out_best_q    <= best_ext[OUT_ROOM_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_room_o  = out_room_q;
  assign actual_start_o  = out_start_q;
  assign actual_finish_o = out_finish_q;
  assign was_delayed_o   = out_delayed_q;
  assign busiest_room_o  = out_best_q;

endmodule
